// ===== sv/tkst_pkg.sv =====
`timescale 1ns / 1ps

package tkst_pkg;

  localparam int K_ENTRIES = 5;
  localparam int TAG_W     = 16;
  localparam int SCORE_W   = 30;
  localparam int CNT_W     = $clog2(K_ENTRIES + 1);

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [TAG_W-1:0]   entry_tag;
    logic [SCORE_W-1:0] score;
  } in_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]   out_tag;
    logic [SCORE_W-1:0] out_score;
    logic               out_valid;
    logic               last;
  } out_req_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rot;
  } cell_ctrl_t;

endpackage

// ===== sv/tkst_cell.sv =====
`timescale 1ns / 1ps

module tkst_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  tkst_pkg::cell_ctrl_t ctrl,
  input  tkst_pkg::entry_t    new_entry,
  input  tkst_pkg::entry_t    prev_entry,
  input  logic                prev_gt,
  input  tkst_pkg::entry_t    next_entry,
  input  tkst_pkg::entry_t    head_entry,
  output tkst_pkg::entry_t    entry,
  output logic                gt
);
  import tkst_pkg::*;

  entry_t entry_r, entry_nxt;

  assign gt    = !entry_r.valid || (new_entry.score > entry_r.score);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (gt) begin
        if (prev_gt) begin
          entry_nxt = prev_entry;
        end else begin
          entry_nxt       = new_entry;
          entry_nxt.valid = 1'b1;
        end
      end
    end else if (ctrl.rot && entry_r.valid) begin
      entry_nxt = next_entry.valid ? next_entry : head_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.tag   <= entry_nxt.tag;
    entry_r.score <= entry_nxt.score;
  end

endmodule

// ===== sv/top_k_score_tracker_unit.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    in_data  (op, entry_tag, score)
// out_      output     out_valid / out_stall  out_data (out_tag, out_score, out_valid, last)
//
// Insert: one request per cycle while in_stall is low; all cells compare in parallel and shift together.
// Read: stalls input until every held entry has been sent out (one empty result on empty); the chain
// rotates one cell per result, so results leave at one per cycle while out_stall is low.
// out_stall holds the output register and pauses the rotation.
// rst_n (sync, active low) empties the chain; stored scores and tags are not cleared.

module top_k_score_tracker_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tkst_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tkst_pkg::out_req_t out_data
);
  import tkst_pkg::*;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_req_t         out_data_r, out_data_nxt;

  logic       in_acc, out_free, is_last;
  cell_ctrl_t ctrl;
  entry_t     new_entry;
  entry_t     cell_q [K_ENTRIES];
  logic       cell_gt [K_ENTRIES];

  assign in_stall  = busy_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign is_last   = (step_r + CNT_W'(1)) == cnt_r;

  assign new_entry = '{valid: 1'b1, tag: in_data.entry_tag, score: in_data.score};
  assign ctrl.ins  = in_acc && (in_data.op == OP_INSERT);
  assign ctrl.rot  = busy_r && out_free && (cnt_r != '0);

  for (genvar i = 0; i < K_ENTRIES; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_g;
    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = cell_q[i-1];
      assign prev_g = cell_gt[i-1];
    end
    if (i == K_ENTRIES - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = cell_q[i+1];
    end
    tkst_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_gt    (prev_g),
      .next_entry (next_e),
      .head_entry (cell_q[0]),
      .entry      (cell_q[i]),
      .gt         (cell_gt[i])
    );
  end

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (ctrl.ins && (cnt_r != CNT_W'(K_ENTRIES))) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (in_acc && (in_data.op == OP_READ)) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end
    if (busy_r && out_free) begin
      out_valid_nxt = 1'b1;
      if (cnt_r == '0) begin
        out_data_nxt      = '0;
        out_data_nxt.last = 1'b1;
        busy_nxt          = 1'b0;
      end else begin
        out_data_nxt = '{out_tag: cell_q[0].tag, out_score: cell_q[0].score,
                         out_valid: 1'b1, last: is_last};
        step_nxt     = step_r + CNT_W'(1);
        if (is_last) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== sv/tkst_checker.sv =====
`timescale 1ns / 1ps

module tkst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input tkst_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input tkst_pkg::out_req_t out_data
);
  import tkst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output request changed");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_valid |-> out_data.last)
    else $error("empty result without last");

  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.op == OP_READ) |=> in_stall)
    else $error("input not stalled after read");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input open during read-out");

endmodule

bind top_k_score_tracker_unit tkst_checker u_tkst_checker (.*);
